// ----- hdl/lsnf_pkg.sv -----
// lsnf_pkg: shared types, widths and reset constants for the lidar sector filter
// no dependencies; imported by every module of the block except lsnf_ram
package lsnf_pkg;

    localparam int XYZ_W      = 16;
    localparam int HLOW_W     = 11;
    localparam int HHIGH_W    = 10;
    localparam int NEAR_W     = 10;
    localparam int RANGE_W    = 15;
    localparam int NEAR_SQ_W  = 2 * NEAR_W;
    localparam int MIN_W      = 31;
    localparam int SQ_W       = 32;
    localparam int AVG_W      = 15;
    localparam int NUM_SECT   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic signed [HLOW_W-1:0] HLOW_RESET    = -11'sd150;
    localparam logic [HHIGH_W-1:0]       HHIGH_RESET   = 10'd150;
    localparam logic [NEAR_SQ_W-1:0]     NEAR_SQ_RESET = 20'd40000;
    localparam logic [MIN_W-1:0]         RANGE_SQ_RESET = 31'd100000000;
    localparam logic [AVG_W-1:0]         WIN_RESET     = 15'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT_LOW,
        CFG_HEIGHT_HIGH,
        CFG_NEAR_LIMIT,
        CFG_NO_RETURN
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SECTOR_FRONT,
        SECTOR_LEFT,
        SECTOR_RIGHT,
        SECTOR_BACK
    } sector_t;

    typedef struct packed {
        logic signed [XYZ_W-1:0] point_x;
        logic signed [XYZ_W-1:0] point_y;
        logic signed [XYZ_W-1:0] point_z;
        logic                    scan_end;
    } point_t;

    typedef struct packed {
        logic [AVG_W-1:0] front_avg;
        logic [AVG_W-1:0] left_avg;
        logic [AVG_W-1:0] right_avg;
    } result_t;

    typedef struct packed {
        logic                  valid;
        cfg_reg_t              index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // per-sector minima of one scan, index 0 front, 1 left, 2 right
    typedef logic [NUM_SECT-1:0][MIN_W-1:0] sector_min_t;

endpackage

// ----- hdl/lidar_sector_nearest_filter.sv -----
// lidar_sector_nearest_filter: top level, front/queue/back wiring and config port
// depends on lsnf_pkg, lsnf_front, lsnf_queue, lsnf_back, lsnf_ram
//
//  channel  direction  handshake            payload
//  pt       in         pt_valid/pt_stall    point_t   (x, y, z, scan_end)
//  res      out        res_valid/res_stall  result_t  (front, left, right avg)
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// points transfer one per cycle unless stalled; each goes through stages a and b to the minima
// each scan end takes the back end through a pop, a square root per sector, a window
// update, a divide per sector and an output
// two finished scans can wait in the queue; past that a scan end in the pipe stalls the input
// reset clears the minima to the no-return range squared and the windows to 10000
// cfg_ready is always high
module lidar_sector_nearest_filter
    import lsnf_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pt_valid,
    output logic                  pt_stall,
    input  point_t                pt_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output result_t               res_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_wr_t     cfg_wr;
    logic        q_push;
    sector_min_t q_push_data;
    logic        q_full;
    logic        q_pop;
    sector_min_t q_pop_data;
    logic        q_empty;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_reg_t'(cfg_index);
    assign cfg_wr.data  = cfg_data;

    lsnf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .pt_data   (pt_data),
        .cfg_wr    (cfg_wr),
        .push      (q_push),
        .push_data (q_push_data),
        .q_full    (q_full)
    );

    lsnf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    lsnf_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_pop_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// ----- hdl/lsnf_ram.sv -----
// lsnf_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies
module lsnf_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/lsnf_front.sv -----
// lsnf_front: point intake, height/range filter, sector classification, per-sector minima
// depends on lsnf_pkg; pushes one minima record per scan into lsnf_queue
module lsnf_front
    import lsnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pt_valid,
    output logic        pt_stall,
    input  point_t      pt_data,
    input  cfg_wr_t     cfg_wr,
    output logic        push,
    output sector_min_t push_data,
    input  logic        q_full
);

    logic signed [HLOW_W-1:0] hlow_reg;
    logic [HHIGH_W-1:0]       hhigh_reg;
    logic [NEAR_SQ_W-1:0]     near_sq_reg;
    logic [MIN_W-1:0]         nr_sq_reg;
    sector_min_t              min_reg;
    sector_min_t              min_next;

    logic             a_valid_reg;
    logic             a_end_reg;
    logic             a_hok_reg;
    sector_t          a_sec_reg;
    logic [XYZ_W-1:0] a_ax_reg;
    logic [XYZ_W-1:0] a_ay_reg;

    logic             b_valid_reg;
    logic             b_end_reg;
    logic             b_hok_reg;
    sector_t          b_sec_reg;
    logic [SQ_W-1:0]  b_sqx_reg;
    logic [SQ_W-1:0]  b_sqy_reg;

    logic                    advance;
    logic signed [XYZ_W:0]   sum_xy;
    logic                    hok;
    sector_t                 sec;
    logic [XYZ_W-1:0]        ax;
    logic [XYZ_W-1:0]        ay;
    logic [SQ_W-1:0]         r2;
    logic                    keep;
    logic                    commit;
    logic [NEAR_SQ_W-1:0]    near_sq_w;
    logic [MIN_W-1:0]        nr_sq_w;

    // the pipeline only holds when a scan end meets a full queue
    assign advance  = !(b_valid_reg && b_end_reg && q_full);
    assign pt_stall = !advance;
    assign commit   = b_valid_reg && advance;

    always_comb
    begin
        sum_xy = {pt_data.point_x[XYZ_W-1], pt_data.point_x}
               + {pt_data.point_y[XYZ_W-1], pt_data.point_y};
        hok = (pt_data.point_z >= hlow_reg)
           && (pt_data.point_z <= $signed({1'b0, hhigh_reg}));
        ax = pt_data.point_x[XYZ_W-1] ? XYZ_W'(-pt_data.point_x) : pt_data.point_x;
        ay = pt_data.point_y[XYZ_W-1] ? XYZ_W'(-pt_data.point_y) : pt_data.point_y;
        // origin belongs to front
        if ((pt_data.point_x == '0 && pt_data.point_y == '0)
            || (pt_data.point_x > 0 && pt_data.point_y <= pt_data.point_x && sum_xy > 0))
        begin
            sec = SECTOR_FRONT;
        end
        else if (pt_data.point_y > 0 && pt_data.point_y > pt_data.point_x && sum_xy >= 0)
        begin
            sec = SECTOR_LEFT;
        end
        else if (pt_data.point_y < 0 && pt_data.point_x > pt_data.point_y && sum_xy <= 0)
        begin
            sec = SECTOR_RIGHT;
        end
        else
        begin
            sec = SECTOR_BACK;
        end
    end

    always_comb
    begin
        r2   = b_sqx_reg + b_sqy_reg;
        keep = b_hok_reg && (b_sec_reg != SECTOR_BACK)
            && (r2 >= {{(SQ_W-NEAR_SQ_W){1'b0}}, near_sq_reg});
        min_next = min_reg;
        for (int i = 0; i < NUM_SECT; i++)
        begin
            // ties keep the old minimum
            if (keep && b_sec_reg == sector_t'(i) && r2 < {1'b0, min_reg[i]})
            begin
                min_next[i] = r2[MIN_W-1:0];
            end
        end
    end

    assign near_sq_w = {{NEAR_W{1'b0}}, cfg_wr.data[NEAR_W-1:0]}
                     * {{NEAR_W{1'b0}}, cfg_wr.data[NEAR_W-1:0]};
    assign nr_sq_w   = {{(MIN_W-RANGE_W){1'b0}}, cfg_wr.data[RANGE_W-1:0]}
                     * {{(MIN_W-RANGE_W){1'b0}}, cfg_wr.data[RANGE_W-1:0]};

    assign push      = commit && b_end_reg;
    assign push_data = min_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hlow_reg    <= HLOW_RESET;
            hhigh_reg   <= HHIGH_RESET;
            near_sq_reg <= NEAR_SQ_RESET;
            nr_sq_reg   <= RANGE_SQ_RESET;
            min_reg     <= {NUM_SECT{RANGE_SQ_RESET}};
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                a_valid_reg <= pt_valid;
                b_valid_reg <= a_valid_reg;
            end
            if (cfg_wr.valid)
            begin
                unique case (cfg_wr.index)
                    CFG_HEIGHT_LOW:  hlow_reg <= cfg_wr.data[HLOW_W-1:0];
                    CFG_HEIGHT_HIGH: hhigh_reg <= cfg_wr.data[HHIGH_W-1:0];
                    CFG_NEAR_LIMIT:  near_sq_reg <= near_sq_w;
                    CFG_NO_RETURN:
                    begin
                        nr_sq_reg <= nr_sq_w;
                        min_reg   <= {NUM_SECT{nr_sq_w}};
                    end
                    default: ;
                endcase
            end
            else if (commit)
            begin
                min_reg <= b_end_reg ? {NUM_SECT{nr_sq_reg}} : min_next;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_end_reg <= pt_data.scan_end;
            a_hok_reg <= hok;
            a_sec_reg <= sec;
            a_ax_reg  <= ax;
            a_ay_reg  <= ay;
            b_end_reg <= a_end_reg;
            b_hok_reg <= a_hok_reg;
            b_sec_reg <= a_sec_reg;
            b_sqx_reg <= {{XYZ_W{1'b0}}, a_ax_reg} * {{XYZ_W{1'b0}}, a_ax_reg};
            b_sqy_reg <= {{XYZ_W{1'b0}}, a_ay_reg} * {{XYZ_W{1'b0}}, a_ay_reg};
        end
    end

endmodule

// ----- hdl/lsnf_queue.sv -----
// lsnf_queue: two-entry queue of per-scan minima between front and back
// depends on lsnf_pkg
module lsnf_queue
    import lsnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sector_min_t push_data,
    output logic        full,
    input  logic        pop,
    output sector_min_t pop_data,
    output logic        empty
);

    sector_min_t mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/lsnf_back.sv -----
// lsnf_back: per-scan square roots, window update and window averages
// depends on lsnf_pkg and lsnf_ram; takes minima records from lsnf_queue
module lsnf_back
    import lsnf_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    output logic        q_pop,
    input  sector_min_t q_data,
    output logic        res_valid,
    input  logic        res_stall,
    output result_t     res_data
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW = $clog2(WINDOW * 32767 + 1);
    localparam int DIV_SH = SW + $clog2(WINDOW);
    localparam int MW = SW + 1;
    localparam int PW = SW + MW;
    localparam logic [MW-1:0] DIV_MUL =
        MW'(((64'd1 << DIV_SH) + 64'(WINDOW - 1)) / 64'(WINDOW));
    localparam logic [1:0]      LAST_SEC  = 2'(NUM_SECT - 1);
    localparam logic [SQ_W-1:0] SQRT_BIT0 = SQ_W'(1) << (SQ_W - 2);

    typedef logic [NUM_SECT-1:0][AVG_W-1:0] sector_val_t;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [1:0]                 sec_reg;
    sector_min_t                rec_reg;
    logic [SQ_W-1:0]            v_reg;
    logic [SQ_W-1:0]            root_acc_reg;
    logic [SQ_W-1:0]            bit_reg;
    sector_val_t                root_reg;
    logic [NUM_SECT-1:0][SW-1:0] sum_reg;
    sector_val_t                avg_reg;
    logic [AW-1:0]              slot_reg;
    logic [WINDOW-1:0]          wvalid_reg;
    logic                       res_valid_reg;
    result_t                    res_data_reg;

    logic [SQ_W-1:0]            sq_trial;
    logic                       sq_ge;
    logic [SQ_W-1:0]            v_next;
    logic [SQ_W-1:0]            root_acc_next;
    logic [PW-1:0]              div_prod;
    logic [AVG_W-1:0]           div_q;
    logic [NUM_SECT-1:0][SW-1:0] sum_next;
    sector_val_t                ram_rd_data;
    logic [AVG_W-1:0]           old_val;
    logic [AW-1:0]              slot_next;
    logic                       res_load;

    // digit-by-digit square root, one result bit per cycle
    always_comb
    begin
        sq_trial = root_acc_reg + bit_reg;
        sq_ge    = (v_reg >= sq_trial);
        v_next   = sq_ge ? (v_reg - sq_trial) : v_reg;
        root_acc_next = sq_ge ? ((root_acc_reg >> 1) + bit_reg) : (root_acc_reg >> 1);
    end

    // divide by the window length as a multiply by its scaled reciprocal
    always_comb
    begin
        div_prod = PW'(sum_reg[sec_reg]) * PW'(DIV_MUL);
        div_q    = div_prod[DIV_SH +: AVG_W];
    end

    // running window sums: drop the overwritten entry, add the new root
    always_comb
    begin
        sum_next = sum_reg;
        old_val  = WIN_RESET;
        for (int i = 0; i < NUM_SECT; i++)
        begin
            old_val     = wvalid_reg[slot_reg] ? ram_rd_data[i] : WIN_RESET;
            sum_next[i] = sum_reg[i] - SW'(old_val) + SW'(root_reg[i]);
        end
        slot_next = (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + AW'(1);
    end

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    // output register is free or hands its transfer over this cycle
    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || !res_stall);

    lsnf_ram #(
        .DW    (NUM_SECT * AVG_W),
        .DEPTH (WINDOW)
    ) u_win_ram (
        .clk     (clk),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (slot_reg),
        .wr_data (root_reg),
        .rd_en   (q_pop),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sec_reg       <= '0;
            slot_reg      <= '0;
            wvalid_reg    <= '0;
            sum_reg       <= {NUM_SECT{SW'(WINDOW * 10000)}};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        rec_reg      <= q_data;
                        sec_reg      <= '0;
                        v_reg        <= {1'b0, q_data[0]};
                        root_acc_reg <= '0;
                        bit_reg      <= SQRT_BIT0;
                        state_reg    <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (bit_reg == SQ_W'(1))
                    begin
                        root_reg[sec_reg] <= root_acc_next[AVG_W-1:0];
                        if (sec_reg == LAST_SEC)
                        begin
                            state_reg <= ST_UPDATE;
                        end
                        else
                        begin
                            sec_reg      <= sec_reg + 2'd1;
                            v_reg        <= {1'b0, rec_reg[sec_reg + 2'd1]};
                            root_acc_reg <= '0;
                            bit_reg      <= SQRT_BIT0;
                        end
                    end
                    else
                    begin
                        v_reg        <= v_next;
                        root_acc_reg <= root_acc_next;
                        bit_reg      <= bit_reg >> 2;
                    end
                end
                ST_UPDATE:
                begin
                    sum_reg              <= sum_next;
                    wvalid_reg[slot_reg] <= 1'b1;
                    slot_reg             <= slot_next;
                    sec_reg              <= '0;
                    state_reg            <= ST_DIV;
                end
                ST_DIV:
                begin
                    avg_reg[sec_reg] <= div_q;
                    if (sec_reg == LAST_SEC)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        sec_reg <= sec_reg + 2'd1;
                    end
                end
                ST_DONE:
                begin
                    // wait for the output register to be free
                    if (res_load)
                    begin
                        res_data_reg.front_avg <= avg_reg[0];
                        res_data_reg.left_avg  <= avg_reg[1];
                        res_data_reg.right_avg <= avg_reg[2];
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ----- hdl/lsnf_checker.sv -----
// lsnf_checker: port-level assertions for lidar_sector_nearest_filter, bound to the top
// depends on lsnf_pkg
module lsnf_checker
    import lsnf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    pt_valid,
    input logic    pt_stall,
    input point_t  pt_data,
    input logic    res_valid,
    input logic    res_stall,
    input result_t res_data
);

    // scan ends taken in but not yet delivered as a result
    logic [3:0] pend_reg;
    logic       end_in;
    logic       res_out;

    assign end_in  = pt_valid && !pt_stall && pt_data.scan_end;
    assign res_out = res_valid && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (end_in && !res_out)
        begin
            pend_reg <= pend_reg + 4'd1;
        end
        else if (res_out && !end_in)
        begin
            pend_reg <= pend_reg - 4'd1;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result dropped or changed while stalled");

    a_res_has_scan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 4'd0)
        else $error("result without a pending scan end");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 4'd6)
        else $error("more scans in flight than pipeline, queue and output can hold");

    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 4'd6 |-> pt_stall)
        else $error("point accepted with every scan slot occupied");

endmodule

bind lidar_sector_nearest_filter lsnf_checker u_lsnf_checker (.*);

// ----- test/sector_avg_checker.sv -----
// sector_avg_checker: watches the point, config and result channels of the lidar sector
// filter, keeps its own copy of the sector minima and windows, and compares every result
// depends on lsnf_pkg
`timescale 1ns / 1ps

module sector_avg_checker
    import lsnf_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pt_valid,
    input  logic                  pt_stall,
    input  point_t                pt_data,
    input  logic                  res_valid,
    input  logic                  res_stall,
    input  result_t               res_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    scans_waiting
);

    localparam int EXP_DEPTH = 64;

    logic signed [HLOW_W-1:0] band_low;
    logic [HHIGH_W-1:0]       band_high;
    logic [NEAR_W-1:0]        near_mm;
    logic [RANGE_W-1:0]       no_return_mm;

    logic [SQ_W-1:0]  nearest_sq [NUM_SECT];
    logic [AVG_W-1:0] history    [NUM_SECT][WINDOW];
    int               slot;

    // ring of expected results, written at scan end, read at each result transfer
    result_t expected_avgs [EXP_DEPTH];
    int      exp_wr = 0;
    int      exp_rd = 0;
    int      fails = 0;
    int      waiting_count = 0;

    assign mismatch_count = fails;
    assign scans_waiting  = waiting_count;

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        fails++;
    endtask

    function automatic sector_t sector_of(input int x, input int y);
        int s;
        s = x + y;
        if ((x == 0 && y == 0) || (x > 0 && y <= x && s > 0))
            return SECTOR_FRONT;
        if (y > 0 && y > x && s >= 0)
            return SECTOR_LEFT;
        if (y < 0 && x > y && s <= 0)
            return SECTOR_RIGHT;
        return SECTOR_BACK;
    endfunction

    // one result bit per pass, from the top down
    function automatic logic [AVG_W-1:0] floor_sqrt(input logic [SQ_W-1:0] v);
        logic [15:0] root;
        logic [15:0] trial;
        int b;
        root = '0;
        for (b = 15; b >= 0; b--)
        begin
            trial = root | (16'd1 << b);
            if (32'(trial) * 32'(trial) <= v)
                root = trial;
        end
        return root[AVG_W-1:0];
    endfunction

    function automatic logic [AVG_W-1:0] window_avg(input sector_t sect);
        int sum;
        int i;
        sum = 0;
        for (i = 0; i < WINDOW; i++)
            sum += history[sect][i];
        return AVG_W'(sum / WINDOW);
    endfunction

    task automatic reload_nearest();
        int k;
        for (k = 0; k < NUM_SECT; k++)
            nearest_sq[k] = 32'(no_return_mm) * 32'(no_return_mm);
    endtask

    task automatic take_point(input point_t p);
        int x;
        int y;
        int z;
        longint ax;
        longint ay;
        longint r2;
        sector_t sect;
        result_t want;
        int k;
        x = $signed(p.point_x);
        y = $signed(p.point_y);
        z = $signed(p.point_z);
        if (z >= int'(band_low) && z <= int'(band_high))
        begin
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            r2 = ax * ax + ay * ay;
            sect = sector_of(x, y);
            if (r2 >= longint'(near_mm) * longint'(near_mm) && sect != SECTOR_BACK)
            begin
                // a tie keeps the old minimum
                if (r2 < longint'(nearest_sq[sect]))
                    nearest_sq[sect] = r2[SQ_W-1:0];
            end
        end
        if (p.scan_end)
        begin
            for (k = 0; k < NUM_SECT; k++)
                history[k][slot] = floor_sqrt(nearest_sq[k]);
            slot = (slot + 1) % WINDOW;
            reload_nearest();
            want.front_avg = window_avg(SECTOR_FRONT);
            want.left_avg  = window_avg(SECTOR_LEFT);
            want.right_avg = window_avg(SECTOR_RIGHT);
            expected_avgs[exp_wr % EXP_DEPTH] = want;
            exp_wr++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_low     = HLOW_RESET;
            band_high    = HHIGH_RESET;
            near_mm      = 10'd200;
            no_return_mm = 15'd10000;
            reload_nearest();
            for (int k = 0; k < NUM_SECT; k++)
                for (int i = 0; i < WINDOW; i++)
                    history[k][i] = WIN_RESET;
            slot = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (exp_wr == exp_rd)
                    log_mismatch("result with no scan end pending", res_data.front_avg, -1);
                else
                begin
                    result_t want;
                    want = expected_avgs[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (res_data.front_avg !== want.front_avg)
                        log_mismatch("front_avg", res_data.front_avg, want.front_avg);
                    if (res_data.left_avg !== want.left_avg)
                        log_mismatch("left_avg", res_data.left_avg, want.left_avg);
                    if (res_data.right_avg !== want.right_avg)
                        log_mismatch("right_avg", res_data.right_avg, want.right_avg);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_HEIGHT_LOW:  band_low  = cfg_data[HLOW_W-1:0];
                    CFG_HEIGHT_HIGH: band_high = cfg_data[HHIGH_W-1:0];
                    CFG_NEAR_LIMIT:  near_mm   = cfg_data[NEAR_W-1:0];
                    CFG_NO_RETURN:
                    begin
                        no_return_mm = cfg_data[RANGE_W-1:0];
                        reload_nearest();
                    end
                    default: ;
                endcase
            end
            if (pt_valid && !pt_stall)
                take_point(pt_data);
        end
        waiting_count = exp_wr - exp_rd;
    end

endmodule

// ----- test/tb.sv -----
// tb: drives points, config writes and result stalls into the lidar sector filter and gives the verdict
// depends on lsnf_pkg, lidar_sector_nearest_filter and sector_avg_checker
`timescale 1ns / 1ps

module tb;
    import lsnf_pkg::*;

    localparam int WINDOW = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pt_valid = 1'b0;
    logic                  pt_stall;
    point_t                pt_data = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    result_t               res_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_HEIGHT_LOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatch_count;
    int scans_waiting;

    // settings the point generator aims at
    int cur_low  = -150;
    int cur_high = 150;
    int cur_near = 200;

    bit pt_burst = 1'b0;
    bit res_burst = 1'b0;
    bit squeeze = 1'b0;

    always #1 clk = ~clk;

    lidar_sector_nearest_filter #(.WINDOW(WINDOW)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .pt_data   (pt_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sector_avg_checker #(.WINDOW(WINDOW)) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pt_valid       (pt_valid),
        .pt_stall       (pt_stall),
        .pt_data        (pt_data),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_data       (res_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .scans_waiting  (scans_waiting)
    );

    task automatic send_point(input point_t p);
        int gap;
        bit taken;
        gap = pt_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            pt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_valid <= 1'b1;
        pt_data  <= p;
        // stall is settled by the falling edge
        do
        begin
            @(negedge clk);
            taken = !pt_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_xyz(input int x, input int y, input int z, input bit last);
        point_t p;
        p.point_x  = 16'(x);
        p.point_y  = 16'(y);
        p.point_z  = 16'(z);
        p.scan_end = last;
        send_point(p);
    endtask

    task automatic write_config(input int lo, input int hi, input int nl, input int nr,
                                input bit [3:0] mask);
        logic [CFG_DATA_W-1:0] vals [4];
        bit rdy;
        int i;
        vals[0] = CFG_DATA_W'(lo);
        vals[1] = CFG_DATA_W'(hi);
        vals[2] = CFG_DATA_W'(nl);
        vals[3] = CFG_DATA_W'(nr);
        pt_valid <= 1'b0;
        @(posedge clk);
        while (scans_waiting != 0) @(posedge clk);
        // wait for points still in the pipe to reach the minima
        repeat (20) @(posedge clk);
        for (i = 0; i < 4; i++)
        begin
            if (mask[i])
            begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_reg_t'(i);
                cfg_data  <= vals[i];
                do
                begin
                    @(negedge clk);
                    rdy = cfg_ready;
                    @(posedge clk);
                end
                while (!rdy);
            end
        end
        cfg_valid <= 1'b0;
        if (mask[0]) cur_low = lo;
        if (mask[1]) cur_high = hi;
        if (mask[2]) cur_near = nl;
    endtask

    function automatic point_t random_point(input bit last);
        point_t p;
        int kind;
        int x;
        int y;
        int z;
        kind = $urandom_range(0, 9);
        x = $urandom_range(0, 5000) - 2500;
        y = $urandom_range(0, 5000) - 2500;
        case (kind)
            0:
            begin
                x = $signed(16'($urandom()));
                y = $signed(16'($urandom()));
            end
            1, 2:
            begin
                // around the near limit
                x = $urandom_range(0, cur_near + 60);
                y = $urandom_range(0, cur_near + 60);
                if ($urandom_range(0, 1)) x = -x;
                if ($urandom_range(0, 1)) y = -y;
            end
            3:
            begin
                // on or next to a sector border
                y = $urandom_range(0, 1) ? x : -x;
                y += $urandom_range(0, 2) - 1;
            end
            4:
            begin
                if ($urandom_range(0, 1)) x = 0;
                else y = 0;
            end
            default: ;
        endcase
        if ($urandom_range(0, 4) == 0)
            z = $signed(16'($urandom()));
        else
            z = cur_low + $urandom_range(0, cur_high - cur_low);
        p.point_x  = 16'(x);
        p.point_y  = 16'(y);
        p.point_z  = 16'(z);
        p.scan_end = last;
        return p;
    endfunction

    // result side: random hold before each transfer, one long hold on request
    initial
    begin : drain
        int hold;
        bit got;
        bit squeeze_done;
        squeeze_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                res_burst = !res_burst;
            if (squeeze && !squeeze_done)
            begin
                hold = 700;
                squeeze_done = 1'b1;
            end
            else if (res_burst)
                hold = 0;
            else
                hold = $urandom_range(0, 9);
            if (hold != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                got = res_valid;
                @(posedge clk);
            end
            while (!got);
        end
    end

    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int sent;
        int len;
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one scan at reset settings: band edges, near limit edge, borders, tie
        send_xyz(0, 0, 0, 1'b0);
        send_xyz(200, 0, 0, 1'b0);
        send_xyz(199, 0, 0, 1'b0);
        send_xyz(0, 300, -150, 1'b0);
        send_xyz(0, -400, 150, 1'b0);
        send_xyz(500, -500, 0, 1'b0);
        send_xyz(-600, 600, 0, 1'b0);
        send_xyz(700, 700, 0, 1'b0);
        send_xyz(50, 400, 151, 1'b0);
        send_xyz(300, 0, -151, 1'b0);
        send_xyz(-32768, -32768, 0, 1'b0);
        send_xyz(32767, 0, 32767, 1'b0);
        send_xyz(0, 32767, -32768, 1'b0);
        send_xyz(200, 0, 0, 1'b1);
        // scan with only a back point, every sector reports no return
        send_xyz(-1000, 5, 0, 1'b1);
        // a no-return write in the middle of a scan drops what came before
        send_xyz(250, 0, 0, 1'b0);
        send_xyz(0, 260, 0, 1'b0);
        write_config(0, 0, 0, 5000, 4'b1000);
        send_xyz(0, -32768, 0, 1'b1);
        // origin only counts with no near limit
        write_config(0, 0, 0, 0, 4'b0100);
        send_xyz(0, 0, 0, 1'b1);
        send_xyz(32767, -32768, 0, 1'b0);
        send_xyz(-32768, 32767, 0, 1'b1);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_config(-150, 150, 200, 10000, 4'b1111);
                1: write_config(-1000, 1000, 0, 32767, 4'b1111);
                2: write_config(0, 0, 1000, 0, 4'b1111);
                default:
                    write_config(-$urandom_range(0, 1000), $urandom_range(0, 1000),
                                 $urandom_range(0, 1000), $urandom_range(0, 32767), 4'b1111);
            endcase
            sent = 0;
            while (sent < 95)
            begin
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(17, 40);
                else
                    len = $urandom_range(1, 12);
                pt_burst = ($urandom_range(0, 3) == 0);
                for (k = 0; k < len; k++)
                    send_point(random_point(k == len - 1));
                sent += len;
            end
        end

        // back-to-back scan ends against a long result hold fill the block up
        squeeze = 1'b1;
        pt_burst = 1'b1;
        for (k = 0; k < 30; k++)
            send_point(random_point(1'b1));
        pt_valid <= 1'b0;

        @(posedge clk);
        while (scans_waiting != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- lidar_sector_nearest_filter.f -----
hdl/lsnf_pkg.sv
hdl/lsnf_ram.sv
hdl/lsnf_front.sv
hdl/lsnf_queue.sv
hdl/lsnf_back.sv
hdl/lidar_sector_nearest_filter.sv
hdl/lsnf_checker.sv
test/sector_avg_checker.sv
test/tb.sv
